### rtl/kvt_pkg.sv
`timescale 1ns / 1ps

package kvt_pkg;

	typedef logic [2:0] mode_t;

	localparam mode_t MODE_INSERT = 3'd0;
	localparam mode_t MODE_UPDATE = 3'd1;
	localparam mode_t MODE_UPSERT = 3'd2;
	localparam mode_t MODE_ERASE  = 3'd3;
	localparam mode_t MODE_LOOKUP = 3'd4;
	localparam mode_t MODE_RANK   = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic load_req;
		logic scan_start;
		logic scan_step;
		logic shift_start;
		logic shift_step;
		logic count_step;
		logic ins_write;
		logic upd_write;
		logic cnt_inc;
		logic cnt_dec;
		logic outer_start;
		logic outer_read;
		logic outer_next;
		logic cand_load;
		logic set_ok;
		logic take_lookup;
		logic take_rank;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		mode_t mode;
		logic  scan_more;
		logic  s1_vld;
		logic  s1_match;
		logic  hit;
		logic  full;
		logic  rank_ok;
		logic  rank_match;
		logic  out_free;
	} sts_t;

endpackage

### rtl/kvt_ram.sv
`timescale 1ns / 1ps

module kvt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/kvt_datapath.sv
`timescale 1ns / 1ps

module kvt_datapath #(
	parameter int CAPACITY = 256,
	parameter int KEY_WIDTH = 32,
	parameter int VALUE_WIDTH = 32,
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [2:0]        mode,
	input  logic [31:0]       req_key,
	input  logic [31:0]       req_value,
	input  logic [7:0]        rank,
	input  logic              out_stall,
	input  kvt_pkg::cmd_t     cmd,
	output kvt_pkg::sts_t     sts,
	output logic              out_valid,
	output logic              ok,
	output logic [31:0]       found_key,
	output logic [31:0]       found_value,
	output logic [CNT_W-1:0]  entry_total
);
	import kvt_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = (CNT_W > 8) ? CNT_W : 8;

	mode_t                  mode_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [7:0]             rank_q;
	logic [CNT_W-1:0]       count_q;
	logic [CNT_W-1:0]       idx_q;
	logic [CNT_W-1:0]       idx_s1;
	logic                   s1_vld_q;
	logic [CNT_W-1:0]       j_q;
	logic [CNT_W-1:0]       less_q;
	logic [AW-1:0]          slot_q;
	logic                   hit_q;
	logic [VALUE_WIDTH-1:0] hit_val_q;
	logic [KEY_WIDTH-1:0]   cand_key_q;
	logic [VALUE_WIDTH-1:0] cand_val_q;
	logic                   res_ok_q;
	logic [KEY_WIDTH-1:0]   res_key_q;
	logic [VALUE_WIDTH-1:0] res_val_q;
	logic                   out_valid_q;
	logic                   ok_q;
	logic [KEY_WIDTH-1:0]   fkey_q;
	logic [VALUE_WIDTH-1:0] fval_q;
	logic [CNT_W-1:0]       total_q;

	logic [63:0]            req_key64;
	logic [63:0]            req_val64;
	logic [63:0]            fkey64;
	logic [63:0]            fval64;
	logic                   scan_more;
	logic                   rd_issue;
	logic                   s1_match;
	logic [AW-1:0]          raddr;
	logic [KEY_WIDTH-1:0]   key_rd;
	logic [VALUE_WIDTH-1:0] val_rd;
	logic                   kwe;
	logic                   vwe;
	logic [AW-1:0]          waddr;
	logic [KEY_WIDTH-1:0]   kwd;
	logic [VALUE_WIDTH-1:0] vwd;
	logic [CNT_W-1:0]       shift_addr;

	assign req_key64 = 64'(req_key);
	assign req_val64 = 64'(req_value);

	assign scan_more  = idx_q < count_q;
	assign rd_issue   = (cmd.scan_step || cmd.shift_step || cmd.count_step) && scan_more;
	assign raddr      = cmd.outer_read ? j_q[AW-1:0] : idx_q[AW-1:0];
	assign s1_match   = s1_vld_q && (key_rd == key_q);
	assign shift_addr = idx_s1 - CNT_W'(1);

	always_comb begin
		kwe   = 1'b0;
		vwe   = 1'b0;
		waddr = count_q[AW-1:0];
		kwd   = key_q;
		vwd   = val_q;
		if (cmd.ins_write) begin
			kwe = 1'b1;
			vwe = 1'b1;
		end else if (cmd.upd_write) begin
			vwe   = 1'b1;
			waddr = slot_q;
		end else if (cmd.shift_step && s1_vld_q) begin
			// move entry down by one slot
			kwe   = 1'b1;
			vwe   = 1'b1;
			waddr = shift_addr[AW-1:0];
			kwd   = key_rd;
			vwd   = val_rd;
		end
	end

	kvt_ram #(.WIDTH(KEY_WIDTH), .DEPTH(CAPACITY)) u_key_ram (
		.clk   (clk),
		.we    (kwe),
		.waddr (waddr),
		.wdata (kwd),
		.raddr (raddr),
		.rdata (key_rd)
	);

	kvt_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(CAPACITY)) u_val_ram (
		.clk   (clk),
		.we    (vwe),
		.waddr (waddr),
		.wdata (vwd),
		.raddr (raddr),
		.rdata (val_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			s1_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			s1_vld_q <= rd_issue;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			mode_q <= mode;
			key_q  <= req_key64[KEY_WIDTH-1:0];
			val_q  <= req_val64[VALUE_WIDTH-1:0];
			rank_q <= rank;
		end

		if (cmd.scan_start || cmd.cand_load) begin
			idx_q <= '0;
		end else if (cmd.shift_start) begin
			idx_q <= CNT_W'(slot_q) + CNT_W'(1);
		end else if (rd_issue) begin
			idx_q <= idx_q + CNT_W'(1);
		end
		idx_s1 <= idx_q;

		if (cmd.load_req) begin
			hit_q <= 1'b0;
		end else if (cmd.scan_step && s1_match) begin
			hit_q     <= 1'b1;
			slot_q    <= idx_s1[AW-1:0];
			hit_val_q <= val_rd;
		end

		if (cmd.outer_start) begin
			j_q <= '0;
		end else if (cmd.outer_next) begin
			j_q <= j_q + CNT_W'(1);
		end

		if (cmd.cand_load) begin
			cand_key_q <= key_rd;
			cand_val_q <= val_rd;
			less_q     <= '0;
		end else if (cmd.count_step && s1_vld_q && (cand_key_q > key_rd)) begin
			less_q <= less_q + CNT_W'(1);
		end

		if (cmd.load_req) begin
			res_ok_q  <= 1'b0;
			res_key_q <= '0;
			res_val_q <= '0;
		end else begin
			if (cmd.set_ok) begin
				res_ok_q <= 1'b1;
			end
			if (cmd.take_lookup) begin
				res_val_q <= hit_val_q;
			end
			if (cmd.take_rank) begin
				res_key_q <= cand_key_q;
				res_val_q <= cand_val_q;
			end
		end

		if (cmd.finish) begin
			ok_q    <= res_ok_q;
			fkey_q  <= res_key_q;
			fval_q  <= res_val_q;
			total_q <= count_q;
		end
	end

	assign fkey64 = 64'(fkey_q);
	assign fval64 = 64'(fval_q);

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign found_key   = fkey64[31:0];
	assign found_value = fval64[31:0];
	assign entry_total = total_q;

	always_comb begin
		sts.mode       = mode_q;
		sts.scan_more  = scan_more;
		sts.s1_vld     = s1_vld_q;
		sts.s1_match   = s1_match;
		sts.hit        = hit_q;
		sts.full       = (count_q == CNT_W'(CAPACITY));
		sts.rank_ok    = CW'(rank_q) < CW'(count_q);
		sts.rank_match = CW'(less_q) == CW'(rank_q);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	a_inc_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> (count_q < CNT_W'(CAPACITY)))
		else $error("entry count grows past capacity");

	a_dec_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_dec |-> (count_q != '0))
		else $error("entry count drops below zero");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld_q |-> (idx_s1 < count_q))
		else $error("read beyond held entries");

endmodule

### rtl/kvt_ctrl.sv
`timescale 1ns / 1ps

module kvt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  kvt_pkg::sts_t  sts,
	output kvt_pkg::cmd_t  cmd
);
	import kvt_pkg::*;

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_DISPATCH = 9'b000000010,
		S_SCAN     = 9'b000000100,
		S_DECIDE   = 9'b000001000,
		S_SHIFT    = 9'b000010000,
		S_R_OUT    = 9'b000100000,
		S_R_WAIT   = 9'b001000000,
		S_R_IN     = 9'b010000000,
		S_FINISH   = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (sts.mode == MODE_RANK) begin
					if (sts.rank_ok) begin
						cmd.outer_start = 1'b1;
						state_d         = S_R_OUT;
					end else begin
						state_d = S_FINISH;
					end
				end else if (sts.mode == MODE_INSERT || sts.mode == MODE_UPDATE ||
				             sts.mode == MODE_UPSERT || sts.mode == MODE_ERASE ||
				             sts.mode == MODE_LOOKUP) begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.s1_match || (!sts.scan_more && !sts.s1_vld)) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_FINISH;
				case (sts.mode)
					MODE_INSERT: begin
						if (!sts.hit && !sts.full) begin
							cmd.ins_write = 1'b1;
							cmd.cnt_inc   = 1'b1;
							cmd.set_ok    = 1'b1;
						end
					end
					MODE_UPDATE: begin
						if (sts.hit) begin
							cmd.upd_write = 1'b1;
							cmd.set_ok    = 1'b1;
						end
					end
					MODE_UPSERT: begin
						if (sts.hit) begin
							cmd.upd_write = 1'b1;
							cmd.set_ok    = 1'b1;
						end else if (!sts.full) begin
							cmd.ins_write = 1'b1;
							cmd.cnt_inc   = 1'b1;
							cmd.set_ok    = 1'b1;
						end
					end
					MODE_ERASE: begin
						if (sts.hit) begin
							cmd.shift_start = 1'b1;
							state_d         = S_SHIFT;
						end
					end
					MODE_LOOKUP: begin
						if (sts.hit) begin
							cmd.take_lookup = 1'b1;
							cmd.set_ok      = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			S_SHIFT: begin
				cmd.shift_step = 1'b1;
				if (!sts.scan_more && !sts.s1_vld) begin
					cmd.cnt_dec = 1'b1;
					cmd.set_ok  = 1'b1;
					state_d     = S_FINISH;
				end
			end
			S_R_OUT: begin
				cmd.outer_read = 1'b1;
				state_d        = S_R_WAIT;
			end
			S_R_WAIT: begin
				cmd.cand_load = 1'b1;
				state_d       = S_R_IN;
			end
			S_R_IN: begin
				cmd.count_step = 1'b1;
				if (!sts.scan_more && !sts.s1_vld) begin
					if (sts.rank_match) begin
						cmd.take_rank = 1'b1;
						cmd.set_ok    = 1'b1;
						state_d       = S_FINISH;
					end else begin
						cmd.outer_next = 1'b1;
						state_d        = S_R_OUT;
					end
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");

	a_load_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_req |=> (state_q == S_DISPATCH))
		else $error("accepted transaction not dispatched");

	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ins_write || cmd.upd_write) |-> cmd.set_ok)
		else $error("table written without success flag");

endmodule

### rtl/key_value_table_engine.sv
`timescale 1ns / 1ps

// Key/value table with linear search, holding up to CAPACITY unique pairs.
// Input channel (in_valid / in_stall): one transaction carries mode, req_key,
// req_value and rank. A transaction is taken when in_valid is high and
// in_stall is low; in_stall stays high from the cycle after acceptance until
// the request is fully processed, so one request is worked on at a time.
// Output channel (out_valid / out_stall): one transaction per request with
// ok, found_key, found_value and entry_total. The result sits in an output
// register and is held while out_stall is high; the next request is accepted
// while an earlier result still waits there, but its own result is held in
// the last step until that register is free.
// With N entries held, a search scans from slot 0 and stops at the first
// hit or after all N entries on a miss; erase of any slot but the last then
// moves the later entries down by one slot; get by rank tries the entries
// in slot order until it reaches the returned one, as each candidate is
// counted against all N keys (one registered read per cycle). Refused ranks
// and unused modes go straight to the result. The input is free again as
// soon as the result is registered.
// Reset clears the entry count and the control state at once; the memories
// are not cleared, since only slots below the entry count are ever read.
module key_value_table_engine #(
	parameter int CAPACITY = 256,
	parameter int KEY_WIDTH = 32,
	parameter int VALUE_WIDTH = 32,
	localparam int CNT_W = $clog2(CAPACITY + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       mode,
	input  logic [31:0]      req_key,
	input  logic [31:0]      req_value,
	input  logic [7:0]       rank,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             ok,
	output logic [31:0]      found_key,
	output logic [31:0]      found_value,
	output logic [CNT_W-1:0] entry_total
);
	import kvt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing: dispatch, scan, modify, rank search, result handoff
	kvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// request registers, key/value memories, counters, result registers
	kvt_datapath #(
		.CAPACITY    (CAPACITY),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.mode        (mode),
		.req_key     (req_key),
		.req_value   (req_value),
		.rank        (rank),
		.out_stall   (out_stall),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.ok          (ok),
		.found_key   (found_key),
		.found_value (found_value),
		.entry_total (entry_total)
	);

endmodule
